/* rtl/core/cur_pkg.sv */
// Package for the chunk upload receiver: word types, codes, control structs
// and register reset values. No dependencies.
package cur_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_LEN,
        PH_PAYLOAD,
        PH_CSUM_HI,
        PH_CSUM_LO,
        PH_END,
        PH_FLASH
    } t_phase;

    typedef enum logic [1:0] {
        FN_BYTE,
        FN_TICK,
        FN_FLASH,
        FN_BEGIN
    } t_func;

    typedef enum logic [2:0] {
        RC_ACK_START,
        RC_ACK_OK,
        RC_NACK_RETRY,
        RC_NACK_ABORT,
        RC_NACK_CORRUPT,
        RC_NACK_FLASH,
        RC_NACK_OVERFLOW
    } t_reply_code;

    typedef enum logic [2:0] {
        ST_OK,
        ST_CORRUPT,
        ST_OVERFLOW,
        ST_RETRIES,
        ST_FLASH_ERR
    } t_status;

    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    localparam logic [1:0] CFG_FLASH_BASE    = 2'd0;
    localparam logic [1:0] CFG_IMAGE_LIMIT   = 2'd1;
    localparam logic [1:0] CFG_RETRY_LIMIT   = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd3;

    localparam logic [31:0] RST_FLASH_BASE    = 32'h0800_8000;
    localparam logic [20:0] RST_IMAGE_LIMIT   = 21'd16384;
    localparam logic [3:0]  RST_RETRY_LIMIT   = 4'd3;
    localparam logic [7:0]  RST_TIMEOUT_TICKS = 8'd2;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;

    typedef struct packed {
        t_func      func;
        logic [7:0] rx_byte;
        logic       prog_pass;
    } t_in_word;

    typedef struct packed {
        logic        kind;
        t_reply_code reply_code;
        logic [31:0] write_address;
        logic [31:0] write_data;
        logic        last;
        logic        session_done;
        t_status     session_status;
    } t_out_word;

    typedef struct packed {
        logic [31:0] flash_base;
        logic [20:0] image_limit;
        logic [3:0]  retry_limit;
        logic [7:0]  timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic        valid;
        t_reply_code code;
        logic        done;
        t_status     status;
    } t_reply;

    typedef struct packed {
        logic        start;
        logic [31:0] base;
    } t_burst;

    typedef struct packed {
        logic       en;
        logic [7:0] pos;
        logic [7:0] data;
    } t_store_wr;

endpackage

/* rtl/core/cur_store.sv */
// Payload memory: byte-lane writes, one word read per cycle, registered data.
// Depends on cur_pkg.
module cur_store
    import cur_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 128
) (
    input  logic                                   i_clk,
    input  t_store_wr                              i_wr,
    input  logic                                   i_rd_en,
    input  logic [((PAYLOAD_BYTES+3)/4 > 1 ? $clog2((PAYLOAD_BYTES+3)/4) : 1)-1:0] i_rd_addr,
    output logic [3:0][7:0]                        o_rd_data
);
    localparam int WORDS = (PAYLOAD_BYTES + 3) / 4;
    localparam int AW    = WORDS > 1 ? $clog2(WORDS) : 1;

    logic [3:0][7:0] r_mem [WORDS];
    logic [3:0][7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[AW'(i_wr.pos >> 2)][i_wr.pos[1:0]] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/cur_ctrl.sv */
// Frame parser and session control: phase, checksum, counters and replies.
// Depends on cur_pkg.
module cur_ctrl
    import cur_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_word  i_word,
    input  t_cfg      i_cfg,
    output t_reply    o_reply,
    output t_burst    o_burst,
    output t_store_wr o_store_wr
);
    t_phase      r_phase, n_phase;
    logic [7:0]  r_start, n_start;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_pos, n_pos;
    logic [15:0] r_sum, n_sum;
    logic [15:0] r_expect, n_expect;
    logic [20:0] r_total, n_total;
    logic [13:0] r_chunk, n_chunk;
    logic [7:0]  r_idle, n_idle;
    logic [3:0]  r_tmo, n_tmo;
    logic [3:0]  r_corrupt, n_corrupt;
    logic [3:0]  r_ffail, n_ffail;

    logic [7:0]  idle_inc;
    logic [3:0]  tmo_inc, cor_inc, ff_inc;
    logic [7:0]  pos_inc;
    logic [15:0] covered;
    logic        tick_to, tmo_abort, cor_abort, ff_abort, ovf, bad;

    assign idle_inc  = r_idle + 8'd1;
    assign tmo_inc   = r_tmo + 4'd1;
    assign cor_inc   = r_corrupt + 4'd1;
    assign ff_inc    = r_ffail + 4'd1;
    assign pos_inc   = r_pos + 8'd1;
    assign tick_to   = idle_inc >= i_cfg.timeout_ticks;
    assign tmo_abort = tmo_inc >= i_cfg.retry_limit;
    assign cor_abort = cor_inc >= i_cfg.retry_limit;
    assign ff_abort  = ff_inc >= i_cfg.retry_limit;
    assign ovf       = r_total > i_cfg.image_limit;
    assign covered   = 16'(r_start) + 16'(r_len) + r_sum;
    assign bad       = covered != r_expect;

    always_comb begin
        n_phase   = r_phase;
        n_start   = r_start;
        n_len     = r_len;
        n_pos     = r_pos;
        n_sum     = r_sum;
        n_expect  = r_expect;
        n_total   = r_total;
        n_chunk   = r_chunk;
        n_idle    = r_idle;
        n_tmo     = r_tmo;
        n_corrupt = r_corrupt;
        n_ffail   = r_ffail;
        if (i_accept) begin
            priority if (i_word.func == FN_BEGIN) begin
                n_total   = '0;
                n_chunk   = '0;
                n_idle    = '0;
                n_tmo     = '0;
                n_corrupt = '0;
                n_ffail   = '0;
                n_expect  = '0;
                n_phase   = PH_START;
                n_pos     = '0;
                n_sum     = '0;
            end else if (r_phase == PH_IDLE) begin
            end else if (i_word.func == FN_FLASH) begin
                if (r_phase == PH_FLASH) begin
                    if (i_word.prog_pass) begin
                        n_ffail = '0;
                        n_phase = PH_START;
                        n_pos   = '0;
                        n_sum   = '0;
                    end else begin
                        n_ffail = ff_inc;
                        n_chunk = r_chunk - 14'd1;
                        if (ff_abort) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_phase = PH_START;
                            n_pos   = '0;
                            n_sum   = '0;
                        end
                    end
                end
            end else if (r_phase == PH_FLASH) begin
            end else if (i_word.func == FN_TICK) begin
                n_idle = tick_to ? 8'd0 : idle_inc;
                if (tick_to) begin
                    n_tmo = tmo_inc;
                    if (tmo_abort) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase = PH_START;
                        n_pos   = '0;
                        n_sum   = '0;
                    end
                end
            end else begin
                n_idle = '0;
                n_tmo  = '0;
                unique case (r_phase)
                    PH_START: begin
                        n_start = i_word.rx_byte;
                        n_phase = PH_LEN;
                    end
                    PH_LEN: begin
                        if (i_word.rx_byte == 8'd0) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_len   = i_word.rx_byte;
                            n_pos   = '0;
                            n_sum   = '0;
                            n_phase = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        if (r_total != '1) begin
                            n_total = r_total + 21'd1;
                        end
                        n_sum = r_sum + 16'(i_word.rx_byte);
                        n_pos = pos_inc;
                        if (32'(pos_inc) >= 32'(PAYLOAD_BYTES)) begin
                            n_phase = PH_CSUM_HI;
                        end
                    end
                    PH_CSUM_HI: begin
                        n_expect = {i_word.rx_byte, 8'd0};
                        n_phase  = PH_CSUM_LO;
                    end
                    PH_CSUM_LO: begin
                        n_expect = {r_expect[15:8], i_word.rx_byte};
                        n_phase  = PH_END;
                    end
                    PH_END: begin
                        if (ovf) begin
                            n_chunk = r_chunk + 14'd1;
                            n_phase = PH_IDLE;
                        end else if (bad) begin
                            n_corrupt = cor_inc;
                            if (cor_abort) begin
                                n_phase = PH_IDLE;
                            end else begin
                                n_phase = PH_START;
                                n_pos   = '0;
                                n_sum   = '0;
                            end
                        end else begin
                            n_corrupt = '0;
                            n_chunk   = r_chunk + 14'd1;
                            n_phase   = PH_FLASH;
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

    always_comb begin
        o_reply        = '{valid: 1'b0, code: RC_ACK_START, done: 1'b0, status: ST_OK};
        o_burst.start  = 1'b0;
        o_burst.base   = i_cfg.flash_base + 32'(r_chunk) * 32'(PAYLOAD_BYTES);
        o_store_wr.en   = 1'b0;
        o_store_wr.pos  = r_pos;
        o_store_wr.data = i_word.rx_byte;
        if (i_accept) begin
            priority if (i_word.func == FN_BEGIN) begin
                o_reply.valid = 1'b1;
            end else if (r_phase == PH_IDLE) begin
            end else if (i_word.func == FN_FLASH) begin
                if (r_phase == PH_FLASH) begin
                    o_reply.valid = 1'b1;
                    if (i_word.prog_pass) begin
                        o_reply.code = RC_ACK_OK;
                    end else begin
                        o_reply.code = RC_NACK_FLASH;
                        if (ff_abort) begin
                            o_reply.done   = 1'b1;
                            o_reply.status = ST_FLASH_ERR;
                        end
                    end
                end
            end else if (r_phase == PH_FLASH) begin
            end else if (i_word.func == FN_TICK) begin
                if (tick_to) begin
                    o_reply.valid = 1'b1;
                    if (tmo_abort) begin
                        o_reply.code   = RC_NACK_ABORT;
                        o_reply.done   = 1'b1;
                        o_reply.status = ST_RETRIES;
                    end else begin
                        o_reply.code = RC_NACK_RETRY;
                    end
                end
            end else begin
                unique case (r_phase)
                    PH_LEN: begin
                        if (i_word.rx_byte == 8'd0) begin
                            o_reply.valid = 1'b1;
                            o_reply.code  = RC_ACK_OK;
                            o_reply.done  = 1'b1;
                        end
                    end
                    PH_PAYLOAD: o_store_wr.en = 1'b1;
                    PH_END: begin
                        if (ovf) begin
                            o_reply.valid  = 1'b1;
                            o_reply.code   = RC_NACK_OVERFLOW;
                            o_reply.done   = 1'b1;
                            o_reply.status = ST_OVERFLOW;
                        end else if (bad) begin
                            o_reply.valid = 1'b1;
                            o_reply.code  = RC_NACK_CORRUPT;
                            if (cor_abort) begin
                                o_reply.done   = 1'b1;
                                o_reply.status = ST_CORRUPT;
                            end
                        end else begin
                            o_burst.start = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_start   <= '0;
            r_len     <= '0;
            r_pos     <= '0;
            r_sum     <= '0;
            r_expect  <= '0;
            r_total   <= '0;
            r_chunk   <= '0;
            r_idle    <= '0;
            r_tmo     <= '0;
            r_corrupt <= '0;
            r_ffail   <= '0;
        end else begin
            r_phase   <= n_phase;
            r_start   <= n_start;
            r_len     <= n_len;
            r_pos     <= n_pos;
            r_sum     <= n_sum;
            r_expect  <= n_expect;
            r_total   <= n_total;
            r_chunk   <= n_chunk;
            r_idle    <= n_idle;
            r_tmo     <= n_tmo;
            r_corrupt <= n_corrupt;
            r_ffail   <= n_ffail;
        end
    end

endmodule

/* rtl/core/cur_outq.sv */
// Four-entry result queue between the control logic and the output channel.
// Depends on cur_pkg.
module cur_outq
    import cur_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_enq,
    input  t_out_word i_enq_word,
    output logic      o_valid,
    output t_out_word o_word,
    input  logic      i_ready,
    output logic [2:0] o_free
);
    t_out_word          r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [2:0]         r_count;
    logic               deq;

    assign o_valid = r_count != 3'd0;
    assign o_word  = r_mem[r_rd_ptr];
    assign o_free  = 3'(OQ_DEPTH) - r_count;
    assign deq     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_enq) begin
            r_mem[r_wr_ptr] <= i_enq_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_enq) begin
                r_wr_ptr <= r_wr_ptr + OQ_AW'(1);
            end
            if (deq) begin
                r_rd_ptr <= r_rd_ptr + OQ_AW'(1);
            end
            r_count <= r_count + 3'(i_enq) - 3'(deq);
        end
    end

endmodule

/* rtl/core/chunk_upload_receiver.sv */
// Top level of the chunk upload receiver: config registers, write-run sequencer,
// payload memory, control and result queue. Depends on cur_pkg, cur_ctrl,
// cur_store and cur_outq.
//
//  channel   direction  signals                                 moves
//  in        input      i_in_valid / o_in_ready / i_in_word     func, byte, flash status
//  out       output     o_out_valid / i_out_ready / o_out_word  reply or flash write
//  cfg       input      i_cfg_we / i_cfg_idx / i_cfg_data       register write
//
// One input word per cycle when not stalled; replies are queued in the same cycle.
// A good chunk emits (PAYLOAD_BYTES+3)/4 write words, one per cycle from the
// payload memory read port while the result queue has room; input is held off
// until the last write word is queued. Input also stalls while the four-entry
// result queue is full. Synchronous active-low reset; no memory clearing pass.
module chunk_upload_receiver
    import cur_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_word,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    localparam int WORDS = (PAYLOAD_BYTES + 3) / 4;
    localparam int AW    = WORDS > 1 ? $clog2(WORDS) : 1;

    t_cfg        r_cfg;
    logic        r_burst, r_pend, r_pend_last;
    logic [AW-1:0] r_word, r_pend_idx;
    logic [31:0] r_addr, r_pend_addr;

    logic        accept, issue, run_end;
    logic [2:0]  free;
    t_reply      reply;
    t_burst      burst;
    t_store_wr   store_wr;
    logic [3:0][7:0] rd_data;
    logic [3:0][7:0] wdata;
    logic        enq;
    t_out_word   enq_word;

    assign o_in_ready = !r_burst && !r_pend && (free != 3'd0);
    assign accept     = i_in_valid && o_in_ready;
    assign issue      = r_burst && (free > 3'(r_pend));
    assign run_end    = r_word == AW'(WORDS - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flash_base    <= RST_FLASH_BASE;
            r_cfg.image_limit   <= RST_IMAGE_LIMIT;
            r_cfg.retry_limit   <= RST_RETRY_LIMIT;
            r_cfg.timeout_ticks <= RST_TIMEOUT_TICKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FLASH_BASE:    r_cfg.flash_base    <= i_cfg_data;
                CFG_IMAGE_LIMIT:   r_cfg.image_limit   <= i_cfg_data[20:0];
                CFG_RETRY_LIMIT:   r_cfg.retry_limit   <= i_cfg_data[3:0];
                CFG_TIMEOUT_TICKS: r_cfg.timeout_ticks <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    cur_ctrl #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_word     (i_in_word),
        .i_cfg      (r_cfg),
        .o_reply    (reply),
        .o_burst    (burst),
        .o_store_wr (store_wr)
    );

    cur_store #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr      (store_wr),
        .i_rd_en   (issue),
        .i_rd_addr (r_word),
        .o_rd_data (rd_data)
    );

    // write-run sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_pend <= issue;
            if (burst.start) begin
                r_burst <= 1'b1;
            end else if (issue && run_end) begin
                r_burst <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (burst.start) begin
            r_word <= '0;
            r_addr <= burst.base;
        end else if (issue) begin
            r_word <= r_word + AW'(1);
            r_addr <= r_addr + 32'd4;
        end
        if (issue) begin
            r_pend_idx  <= r_word;
            r_pend_addr <= r_addr;
            r_pend_last <= run_end;
        end
    end

    // bytes past the payload end read as zero
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            wdata[l] = ((32'(r_pend_idx) * 32'd4 + 32'(l)) < 32'(PAYLOAD_BYTES)) ?
                       rd_data[l] : 8'd0;
        end
    end

    always_comb begin
        enq      = r_pend || reply.valid;
        enq_word = '{kind: KIND_REPLY, reply_code: reply.code, write_address: 32'd0,
                     write_data: 32'd0, last: 1'b1, session_done: reply.done,
                     session_status: reply.status};
        if (r_pend) begin
            enq_word = '{kind: KIND_WRITE, reply_code: RC_ACK_START,
                         write_address: r_pend_addr, write_data: wdata,
                         last: r_pend_last, session_done: 1'b0, session_status: ST_OK};
        end
    end

    cur_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_enq      (enq),
        .i_enq_word (enq_word),
        .o_valid    (o_out_valid),
        .o_word     (o_out_word),
        .i_ready    (i_out_ready),
        .o_free     (free)
    );

endmodule

/* rtl/core/cur_check.sv */
// Port-level assertions for the chunk upload receiver, bound to the top level.
// Depends on cur_pkg.
module cur_check
    import cur_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_word.kind == KIND_WRITE && !o_out_word.last
        |=> !o_out_valid || o_out_word.kind == KIND_WRITE)
        else $error("write run interrupted by a reply");

    a_reply_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.kind == KIND_REPLY |-> o_out_word.last)
        else $error("reply without last");

    a_status_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.session_done |-> o_out_word.session_status == ST_OK)
        else $error("session status without session end");

endmodule

bind chunk_upload_receiver cur_check u_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

/* tb/tb_chunk_upload_receiver.sv */
// Testbench for chunk_upload_receiver: random framed chunk sessions checked word by word
// against an in-bench model of the upload protocol. Depends on cur_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_chunk_upload_receiver;
    import cur_pkg::*;

    localparam int PAYLOAD_BYTES = 128;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT   = 4000;

    class upload_tracker #(int CHUNK_BYTES = 128);
        localparam int CHUNK_WORDS = (CHUNK_BYTES + 3) / 4;

        t_cfg        cfg = '{RST_FLASH_BASE, RST_IMAGE_LIMIT, RST_RETRY_LIMIT,
                             RST_TIMEOUT_TICKS};
        t_phase      phase = PH_IDLE;
        logic [7:0]  frame_start = '0;
        logic [7:0]  frame_len = '0;
        logic [7:0]  chunk_data [CHUNK_BYTES];
        logic [7:0]  fill_pos = '0;
        logic [15:0] data_sum = '0;
        logic [15:0] sent_sum = '0;
        logic [20:0] byte_total = '0;
        logic [13:0] chunk_num = '0;
        logic [7:0]  tick_count = '0;
        logic [3:0]  timeout_runs = '0;
        logic [3:0]  bad_chunks = '0;
        logic [3:0]  prog_fails = '0;
        t_out_word   awaited_words [$];
        int          mismatches = 0;

        function void restart_frame();
            phase = PH_START;
            fill_pos = '0;
            data_sum = '0;
        endfunction

        function void push_reply(t_reply_code code, logic done, t_status status);
            t_out_word r;
            r = '0;
            r.kind = KIND_REPLY;
            r.reply_code = code;
            r.last = 1'b1;
            r.session_done = done;
            r.session_status = done ? status : ST_OK;
            awaited_words.push_back(r);
        endfunction

        // end byte: overflow, then checksum, then the write run
        function void close_chunk();
            logic [15:0] covered;
            logic [13:0] prev_chunk;
            logic [31:0] base;
            t_out_word   r;
            chunk_num++;
            if (byte_total > cfg.image_limit) begin
                phase = PH_IDLE;
                push_reply(RC_NACK_OVERFLOW, 1'b1, ST_OVERFLOW);
                return;
            end
            covered = 16'(frame_start) + 16'(frame_len) + data_sum;
            if (covered != sent_sum) begin
                bad_chunks++;
                chunk_num--;
                if (bad_chunks >= cfg.retry_limit) begin
                    phase = PH_IDLE;
                    push_reply(RC_NACK_CORRUPT, 1'b1, ST_CORRUPT);
                end else begin
                    restart_frame();
                    push_reply(RC_NACK_CORRUPT, 1'b0, ST_OK);
                end
                return;
            end
            bad_chunks = '0;
            prev_chunk = chunk_num - 14'd1;
            base = cfg.flash_base + 32'(CHUNK_BYTES) * 32'(prev_chunk);
            for (int i = 0; i < CHUNK_WORDS; i++) begin
                r = '0;
                r.kind = KIND_WRITE;
                r.reply_code = RC_ACK_START;
                r.write_address = base + 32'(4 * i);
                for (int b = 0; b < 4; b++)
                    if (4 * i + b < CHUNK_BYTES)
                        r.write_data[8 * b +: 8] = chunk_data[4 * i + b];
                r.last = (i == CHUNK_WORDS - 1);
                awaited_words.push_back(r);
            end
            phase = PH_FLASH;
        endfunction

        // returns 0 when the block ignores the word
        function bit take_input_word(t_in_word w);
            if (w.func == FN_BEGIN) begin
                byte_total = '0;
                chunk_num = '0;
                tick_count = '0;
                timeout_runs = '0;
                bad_chunks = '0;
                prog_fails = '0;
                sent_sum = '0;
                restart_frame();
                push_reply(RC_ACK_START, 1'b0, ST_OK);
                return 1'b1;
            end
            if (phase == PH_IDLE) return 1'b0;
            if (w.func == FN_FLASH) begin
                if (phase != PH_FLASH) return 1'b0;
                if (w.prog_pass) begin
                    prog_fails = '0;
                    restart_frame();
                    push_reply(RC_ACK_OK, 1'b0, ST_OK);
                    return 1'b1;
                end
                prog_fails++;
                chunk_num--;
                if (prog_fails >= cfg.retry_limit) begin
                    phase = PH_IDLE;
                    push_reply(RC_NACK_FLASH, 1'b1, ST_FLASH_ERR);
                end else begin
                    restart_frame();
                    push_reply(RC_NACK_FLASH, 1'b0, ST_OK);
                end
                return 1'b1;
            end
            if (phase == PH_FLASH) return 1'b0;
            if (w.func == FN_TICK) begin
                tick_count++;
                if (tick_count < cfg.timeout_ticks) return 1'b1;
                tick_count = '0;
                timeout_runs++;
                if (timeout_runs >= cfg.retry_limit) begin
                    phase = PH_IDLE;
                    push_reply(RC_NACK_ABORT, 1'b1, ST_RETRIES);
                end else begin
                    restart_frame();
                    push_reply(RC_NACK_RETRY, 1'b0, ST_OK);
                end
                return 1'b1;
            end
            tick_count = '0;
            timeout_runs = '0;
            case (phase)
                PH_START: begin
                    frame_start = w.rx_byte;
                    phase = PH_LEN;
                end
                PH_LEN: begin
                    if (w.rx_byte == 8'h00) begin
                        phase = PH_IDLE;
                        push_reply(RC_ACK_OK, 1'b1, ST_OK);
                    end else begin
                        frame_len = w.rx_byte;
                        fill_pos = '0;
                        data_sum = '0;
                        phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (byte_total != '1) byte_total++;
                    if (fill_pos < CHUNK_BYTES) chunk_data[fill_pos] = w.rx_byte;
                    data_sum = data_sum + 16'(w.rx_byte);
                    fill_pos++;
                    if (fill_pos >= CHUNK_BYTES) phase = PH_CSUM_HI;
                end
                PH_CSUM_HI: begin
                    sent_sum = {w.rx_byte, 8'h00};
                    phase = PH_CSUM_LO;
                end
                PH_CSUM_LO: begin
                    sent_sum = sent_sum | 16'(w.rx_byte);
                    phase = PH_END;
                end
                PH_END: close_chunk();
                default: phase = PH_IDLE;
            endcase
            return 1'b1;
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t ns mismatch %s: got %h want %h", $time, what, got, want);
            mismatches++;
        endtask

        task match_output_word(t_out_word got);
            t_out_word want;
            if (awaited_words.size() == 0) begin
                report("unexpected word, address", got.write_address, '0);
                return;
            end
            want = awaited_words.pop_front();
            if (got.kind !== want.kind) report("kind", got.kind, want.kind);
            if (got.reply_code !== want.reply_code)
                report("reply_code", got.reply_code, want.reply_code);
            if (got.write_address !== want.write_address)
                report("write_address", got.write_address, want.write_address);
            if (got.write_data !== want.write_data)
                report("write_data", got.write_data, want.write_data);
            if (got.last !== want.last) report("last", got.last, want.last);
            if (got.session_done !== want.session_done)
                report("session_done", got.session_done, want.session_done);
            if (got.session_status !== want.session_status)
                report("session_status", got.session_status, want.session_status);
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_word    in_word = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_word   out_word;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = CFG_FLASH_BASE;
    logic [31:0] cfg_data = '0;

    upload_tracker #(PAYLOAD_BYTES) tracker = new;
    int  src_idle_pct = 15;
    int  sink_idle_pct = 15;
    bit  hold_request = 1'b0;
    int  quiet_cycles = 0;
    int  items_used = 0;

    chunk_upload_receiver #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_word (out_word),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid === 1'b1 && out_ready)
            tracker.match_output_word(out_word);
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_chunk_upload_receiver NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result sink, with one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                repeat (HOLD_CYCLES) begin
                    out_ready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            out_ready <= i_rst_n && ($urandom_range(99) >= sink_idle_pct);
        end
    end

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_word(t_func f, logic [7:0] b, logic ok);
        t_in_word w;
        w.func = f;
        w.rx_byte = b;
        w.prog_pass = ok;
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        do @(posedge i_clk); while (in_ready !== 1'b1);
        if (tracker.take_input_word(w)) items_used++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_word(FN_BYTE, b, 1'($urandom_range(1)));
    endtask

    task automatic send_tick();
        send_word(FN_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    task automatic open_frame();
        if (tracker.phase != PH_START)
            send_word(FN_BEGIN, rand_byte(), 1'($urandom_range(1)));
    endtask

    // cut < 0 sends the whole frame, else only its first cut bytes
    task automatic send_frame(logic corrupt, int cut);
        logic [7:0]  frame_bytes [$];
        logic [7:0]  len;
        logic [15:0] sum;
        int          n;
        frame_bytes.push_back(rand_byte());
        len = rand_byte();
        frame_bytes.push_back(len == 8'h00 ? 8'h01 : len);
        repeat (PAYLOAD_BYTES) frame_bytes.push_back(rand_byte());
        sum = '0;
        foreach (frame_bytes[k]) sum = sum + 16'(frame_bytes[k]);
        if (corrupt) sum = sum ^ 16'($urandom_range(1, 65535));
        frame_bytes.push_back(sum[15:8]);
        frame_bytes.push_back(sum[7:0]);
        frame_bytes.push_back(rand_byte());
        n = (cut < 0) ? frame_bytes.size() : cut;
        for (int k = 0; k < n; k++) begin
            // a lone tick after a byte stays below the timeout
            if (k > 0 && tracker.cfg.timeout_ticks > 8'd1 && $urandom_range(99) < 3)
                send_tick();
            send_byte(frame_bytes[k]);
        end
    endtask

    task automatic good_chunk();
        open_frame();
        send_frame(1'b0, -1);
        if (tracker.phase == PH_FLASH) begin
            repeat ($urandom_range(2)) begin
                if ($urandom_range(1)) send_byte(rand_byte());
                else send_tick();
            end
            send_word(FN_FLASH, rand_byte(), $urandom_range(99) < 70);
        end
    endtask

    task automatic run_random(int budget);
        int first;
        int r;
        first = items_used;
        while (items_used - first < budget) begin
            r = $urandom_range(99);
            if (r < 35) begin
                good_chunk();
            end else if (r < 45) begin
                open_frame();
                send_frame(1'b1, -1);
            end else if (r < 53) begin
                open_frame();
                send_frame(1'b0, $urandom_range(1, PAYLOAD_BYTES + 4));
                repeat ($urandom_range(1, 4)) send_tick();
            end else if (r < 60) begin
                open_frame();
                send_byte(rand_byte());
                send_byte(8'h00);
            end else if (r < 70) begin
                repeat ($urandom_range(1, 4)) send_tick();
            end else if (r < 78) begin
                send_word(FN_BEGIN, rand_byte(), 1'($urandom_range(1)));
            end else begin
                send_word(t_func'($urandom_range(3)), rand_byte(), 1'($urandom_range(1)));
            end
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.awaited_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(logic [1:0] idx, logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic set_config(t_cfg c);
        put_reg(CFG_FLASH_BASE, c.flash_base);
        put_reg(CFG_IMAGE_LIMIT, 32'(c.image_limit));
        put_reg(CFG_RETRY_LIMIT, 32'(c.retry_limit));
        put_reg(CFG_TIMEOUT_TICKS, 32'(c.timeout_ticks));
        cfg_we <= 1'b0;
        tracker.cfg = c;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ignored while idle, then begin a session
        send_byte(8'h00);
        send_tick();
        send_word(FN_FLASH, 8'hFF, 1'b1);
        send_word(FN_BEGIN, 8'hFF, 1'b1);
        // stray status, then zero length ends the session
        send_word(FN_FLASH, 8'h00, 1'b0);
        send_byte(8'hFF);
        send_byte(8'h00);
        // two retries, then abort on timeouts
        send_word(FN_BEGIN, 8'h00, 1'b0);
        repeat (6) send_tick();
        // timeout inside the payload, then begin mid-frame
        send_word(FN_BEGIN, 8'h5A, 1'b0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hAA);
        send_tick();
        send_tick();
        send_byte(8'h55);
        send_byte(8'h01);
        send_word(FN_BEGIN, 8'hA5, 1'b1);
        run_random(1);

        settle();
        set_config(t_cfg'{32'hFFFF_FFFF, 21'h10_0000, 4'd15, 8'd255});
        src_idle_pct = 0;
        sink_idle_pct = 0;
        hold_request = 1'b1;
        good_chunk();

        settle();
        src_idle_pct = 15;
        sink_idle_pct = 15;
        set_config(t_cfg'{32'h0000_0000, 21'd0, 4'd1, 8'd1});
        run_random(1);

        settle();
        set_config(t_cfg'{32'($urandom), 21'd200, 4'd2, 8'd3});
        run_random(1);

        settle();
        set_config(t_cfg'{32'($urandom), 21'($urandom_range(1048576)), 4'd0, 8'd0});
        run_random(1);

        settle();
        if (tracker.mismatches == 0) begin
            $display("tb_chunk_upload_receiver OK");
        end else begin
            $display("tb_chunk_upload_receiver NOT OK");
        end
        $finish;
    end

endmodule
